// File: src/esc_pkg.sv
// shared types and constants for the environmental sensor compensation unit
// no dependencies; imported by every module of the block
package esc_pkg;

    // register map, one 64-bit slot per register
    typedef enum logic [2:0] {
        REG_TEMP   = 3'd0,
        REG_PRES_A = 3'd1,
        REG_PRES_B = 3'd2,
        REG_PRES_C = 3'd3,
        REG_HUM_A  = 3'd4,
        REG_HUM_B  = 3'd5
    } t_reg_idx;

    // flags that ride along with the pressure divide
    typedef struct packed {
        logic fault;   // divisor was zero
        logic big;     // dividend at or above the overflow limit, shift after divide
    } t_div_side;

    localparam int DIV_BITS   = 32;
    localparam int DIV_LAT    = DIV_BITS + 2;      // magnitude stage, bit steps, sign stage
    localparam int PRE_DEPTH  = 10;                // stages before the divider
    localparam int PIPE_DEPTH = PRE_DEPTH + DIV_LAT + 4;
    localparam int HUM_END    = 17;                // stage that holds clamped humidity
    localparam int HUM_DLY    = PIPE_DEPTH - HUM_END;

    // reciprocal of 100 scaled by 2**37, exact for any 32-bit magnitude
    localparam logic [30:0] RECIP_100 = 31'h51EB851F;
    localparam int          RECIP_SHIFT = 37;

    localparam logic signed [31:0] OVF_LIMIT = 32'sh40000000;
    localparam logic [16:0]        HUM_MAX   = 17'd100000;

endpackage

// File: src/esc_div100.sv
// two-stage signed divide by 100, truncating toward zero
// depends on esc_pkg for the reciprocal constant
module esc_div100 (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_x,
    output logic signed [31:0] o_q
);
    import esc_pkg::*;

    logic [31:0]        mag;
    logic [62:0]        r_prod;
    logic               r_neg;
    logic [25:0]        quo;
    logic signed [31:0] r_q;

    // magnitude times reciprocal
    assign mag = i_x[31] ? (~i_x + 32'd1) : i_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 63'(mag) * 63'(RECIP_100);
            r_neg  <= i_x[31];
        end
    end

    // shift down and restore sign
    assign quo = r_prod[62:RECIP_SHIFT];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_neg ? -$signed({6'd0, quo}) : $signed({6'd0, quo});
        end
    end

    assign o_q = r_q;

endmodule

// File: src/esc_sdiv.sv
// pipelined 32-bit signed divider, one quotient bit per stage, truncating
// depends on esc_pkg for the side flag struct and the bit count
module esc_sdiv (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [31:0]   i_dividend,
    input  logic signed [31:0]   i_divisor,
    input  esc_pkg::t_div_side   i_side,
    output logic signed [31:0]   o_quotient,
    output esc_pkg::t_div_side   o_side
);
    import esc_pkg::*;

    logic [31:0] r_rem [0:DIV_BITS];
    logic [31:0] r_quo [0:DIV_BITS];
    logic [31:0] r_den [0:DIV_BITS];
    logic        r_neg [0:DIV_BITS];
    t_div_side   r_sd  [0:DIV_BITS];

    logic signed [31:0] r_out;
    t_div_side          r_out_sd;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= i_dividend[31] ? (~i_dividend + 32'd1) : i_dividend;
            r_den[0] <= i_divisor[31] ? (~i_divisor + 32'd1) : i_divisor;
            r_neg[0] <= i_dividend[31] ^ i_divisor[31];
            r_sd[0]  <= i_side;
        end
    end

    // restoring steps, dividend bits shift out as quotient bits shift in
    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_step
        logic [32:0] trial;
        logic [32:0] diff;
        assign trial = {r_rem[k-1], r_quo[k-1][31]};
        assign diff  = trial - {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!diff[32]) begin
                    r_rem[k] <= diff[31:0];
                    r_quo[k] <= {r_quo[k-1][30:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[31:0];
                    r_quo[k] <= {r_quo[k-1][30:0], 1'b0};
                end
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_sd[k]  <= r_sd[k-1];
            end
        end
    end

    // apply sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out    <= r_neg[DIV_BITS] ? -$signed(r_quo[DIV_BITS]) : $signed(r_quo[DIV_BITS]);
            r_out_sd <= r_sd[DIV_BITS];
        end
    end

    assign o_quotient = r_out;
    assign o_side     = r_out_sd;

endmodule

// File: src/env_sensor_compensation_unit.sv
// top level: register port, temperature, pressure and humidity pipelines
// depends on esc_pkg, esc_div100 and esc_sdiv
//
// Compensates one raw temperature/pressure/humidity triple per transaction. The
// pipeline takes a new transaction every clock unless stalled, through 48 register
// stages; that depth is set by the 34-stage pressure divider (an entry stage, 32
// quotient bit steps and a sign stage), with the temperature front end and the
// pressure pre-scaling ahead of it and three post-divide stages plus the output
// register behind it. A stall on a valid output holds the whole pipeline and is
// passed back on o_stall in the same cycle. Coefficients live in six 64-bit slots at
// byte addresses 0x00..0x28 and must only be changed while no transaction is in
// flight. A zero pressure divisor returns pressure 0 with o_divide_fault set.
module env_sensor_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // sample channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_temperature,
    input  logic [19:0] i_raw_pressure,
    input  logic [15:0] i_raw_humidity,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_temperature_centi,
    output logic [31:0] o_pressure_pa,
    output logic [16:0] o_humidity_milli,
    output logic        o_divide_fault
);
    import esc_pkg::*;

    // ---------------------------------------------------------------- registers
    logic [39:0] r_temp;
    logic [55:0] r_pres_a;
    logic [47:0] r_pres_b;
    logic [23:0] r_pres_c;
    logic [23:0] r_hum_a;
    logic [39:0] r_hum_b;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[5:3]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp   <= '0;
            r_pres_a <= '0;
            r_pres_b <= '0;
            r_pres_c <= '0;
            r_hum_a  <= '0;
            r_hum_b  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TEMP:   r_temp   <= pwdata[39:0];
                REG_PRES_A: r_pres_a <= pwdata[55:0];
                REG_PRES_B: r_pres_b <= pwdata[47:0];
                REG_PRES_C: r_pres_c <= pwdata[23:0];
                REG_HUM_A:  r_hum_a  <= pwdata[23:0];
                REG_HUM_B:  r_hum_b  <= pwdata[39:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (cfg_idx)
            REG_TEMP:   prdata = {24'd0, r_temp};
            REG_PRES_A: prdata = {8'd0, r_pres_a};
            REG_PRES_B: prdata = {16'd0, r_pres_b};
            REG_PRES_C: prdata = {40'd0, r_pres_c};
            REG_HUM_A:  prdata = {40'd0, r_hum_a};
            REG_HUM_B:  prdata = {24'd0, r_hum_b};
            default:    prdata = '0;
        endcase
    end

    // coefficient fields
    logic [15:0]        c_t1;
    logic signed [15:0] c_t2;
    logic signed [7:0]  c_t3;
    logic signed [31:0] c_p1, c_p2, c_p3, c_p4, c_p5, c_p6, c_p7, c_p8, c_p9, c_p10;
    logic signed [31:0] c_h1, c_h2, c_h3, c_h4, c_h5, c_h6, c_h7;

    always_comb begin
        c_t1  = r_temp[15:0];
        c_t2  = $signed(r_temp[31:16]);
        c_t3  = $signed(r_temp[39:32]);
        c_p1  = $signed({16'd0, r_pres_a[15:0]});
        c_p2  = 32'($signed(r_pres_a[31:16]));
        c_p3  = 32'($signed(r_pres_a[39:32]));
        c_p4  = 32'($signed(r_pres_a[55:40]));
        c_p5  = 32'($signed(r_pres_b[15:0]));
        c_p6  = 32'($signed(r_pres_b[23:16]));
        c_p7  = 32'($signed(r_pres_b[31:24]));
        c_p8  = 32'($signed(r_pres_b[47:32]));
        c_p9  = 32'($signed(r_pres_c[15:0]));
        c_p10 = $signed({24'd0, r_pres_c[23:16]});
        c_h1  = $signed({20'd0, r_hum_a[11:0]});
        c_h2  = $signed({20'd0, r_hum_a[23:12]});
        c_h3  = 32'($signed(r_hum_b[7:0]));
        c_h4  = 32'($signed(r_hum_b[15:8]));
        c_h5  = 32'($signed(r_hum_b[23:16]));
        c_h6  = $signed({24'd0, r_hum_b[31:24]});
        c_h7  = 32'($signed(r_hum_b[39:32]));
    end

    // ---------------------------------------------------------------- flow control
    logic                  adv;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign adv     = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // ---------------------------------------------------------------- temperature
    logic signed [18:0] r_ta;
    logic [19:0]        r_s1_rp;
    logic [15:0]        r_s1_rh;

    // stage 1: offset raw reading
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ta    <= $signed({2'b00, i_raw_temperature[19:3]}) - $signed({2'b00, c_t1, 1'b0});
            r_s1_rp <= i_raw_pressure;
            r_s1_rh <= i_raw_humidity;
        end
    end

    // stage 2: linear and square products
    logic signed [17:0] ta_half;
    logic signed [34:0] r_tb_prod;
    logic signed [35:0] r_tc_sq;
    logic [19:0]        r_s2_rp;
    logic [15:0]        r_s2_rh;

    assign ta_half = r_ta[18:1];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tb_prod <= r_ta * c_t2;
            r_tc_sq   <= ta_half * ta_half;
            r_s2_rp   <= r_s1_rp;
            r_s2_rh   <= r_s1_rh;
        end
    end

    // stage 3: cubic term product
    logic signed [34:0] tb_shr;
    logic signed [35:0] tc_shr;
    logic signed [23:0] tc_sq;
    logic signed [11:0] t3x16;
    logic signed [23:0] r_tb;
    logic signed [35:0] r_tc_prod;
    logic [19:0]        r_s3_rp;
    logic [15:0]        r_s3_rh;

    assign tb_shr = r_tb_prod >>> 11;
    assign tc_shr = r_tc_sq >>> 12;
    assign tc_sq  = $signed(tc_shr[23:0]);
    assign t3x16  = {c_t3, 4'd0};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tb      <= $signed(tb_shr[23:0]);
            r_tc_prod <= tc_sq * t3x16;
            r_s3_rp   <= r_s2_rp;
            r_s3_rh   <= r_s2_rh;
        end
    end

    // stage 4: fine temperature
    logic signed [35:0] tc_fin;
    logic signed [31:0] r_tf;
    logic [19:0]        r_s4_rp;
    logic [15:0]        r_s4_rh;

    assign tc_fin = r_tc_prod >>> 14;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tf    <= 32'(r_tb) + $signed(tc_fin[31:0]);
            r_s4_rp <= r_s3_rp;
            r_s4_rh <= r_s3_rh;
        end
    end

    // stage 5: centidegrees and pressure offset
    logic signed [31:0] ts_pre;
    logic signed [31:0] r_ts;
    logic signed [31:0] r_pv1;
    logic [19:0]        r_s5_rp;
    logic [15:0]        r_s5_rh;

    assign ts_pre = r_tf * 32'sd5 + 32'sd128;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ts    <= ts_pre >>> 8;
            r_pv1   <= (r_tf >>> 1) - 32'sd64000;
            r_s5_rp <= r_s4_rp;
            r_s5_rh <= r_s4_rh;
        end
    end

    // ---------------------------------------------------------------- pressure
    logic signed [31:0] pq;
    logic signed [31:0] r_p1_qq, r_p1_v1p5, r_p1_p2v1;
    logic [19:0]        r_p1_rp;

    assign pq = r_pv1 >>> 2;

    // stage 6: first products
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1_qq   <= pq * pq;
            r_p1_v1p5 <= r_pv1 * c_p5;
            r_p1_p2v1 <= c_p2 * r_pv1;
            r_p1_rp   <= r_s5_rp;
        end
    end

    // stage 7: coefficient products
    logic signed [31:0] r_p2_x, r_p2_y, r_p2_v1p5, r_p2_p2v1;
    logic [19:0]        r_p2_rp;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p2_x    <= (r_p1_qq >>> 11) * c_p6;
            r_p2_y    <= (r_p1_qq >>> 13) * (c_p3 <<< 5);
            r_p2_v1p5 <= r_p1_v1p5;
            r_p2_p2v1 <= r_p1_p2v1;
            r_p2_rp   <= r_p1_rp;
        end
    end

    // stage 8: combine into var1 and var2
    logic signed [31:0] pv2a, pv1a;
    logic signed [31:0] r_p3_v1, r_p3_v2;
    logic [19:0]        r_p3_rp;

    assign pv2a = (r_p2_x >>> 2) + (r_p2_v1p5 <<< 1);
    assign pv1a = (r_p2_y >>> 3) + (r_p2_p2v1 >>> 1);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p3_v2 <= (pv2a >>> 2) + (c_p4 <<< 16);
            r_p3_v1 <= pv1a >>> 18;
            r_p3_rp <= r_p2_rp;
        end
    end

    // stage 9: divisor product and raw offset
    logic signed [31:0] r_p4_m, r_p4_pc0;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p4_m   <= (32'sd32768 + r_p3_v1) * c_p1;
            r_p4_pc0 <= 32'sd1048576 - $signed({12'd0, r_p3_rp}) - (r_p3_v2 >>> 12);
        end
    end

    // stage 10: divisor and scaled dividend
    logic signed [31:0] r_p5_v1, r_p5_pc;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p5_v1 <= r_p4_m >>> 15;
            r_p5_pc <= r_p4_pc0 * 32'sd3125;
        end
    end

    // divide
    logic               pbig;
    logic signed [31:0] pdividend;
    t_div_side          dv_side_in, dv_side_out;
    logic signed [31:0] dv_quo;

    assign pbig             = (r_p5_pc >= OVF_LIMIT);
    assign pdividend        = pbig ? r_p5_pc : (r_p5_pc <<< 1);
    assign dv_side_in.fault = (r_p5_v1 == 32'sd0);
    assign dv_side_in.big   = pbig;

    esc_sdiv u_sdiv (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend (pdividend),
        .i_divisor  (r_p5_v1),
        .i_side     (dv_side_in),
        .o_quotient (dv_quo),
        .o_side     (dv_side_out)
    );

    // post-divide stage 1: squares and coefficient product
    logic signed [31:0] pcd, pq3, pq8;
    logic signed [31:0] r_q1_pc, r_q1_qq, r_q1_a2, r_q1_q82, r_q1_q8;
    logic               r_q1_fault;

    assign pcd = dv_side_out.big ? (dv_quo <<< 1) : dv_quo;
    assign pq3 = pcd >>> 3;
    assign pq8 = pcd >>> 8;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q1_pc    <= pcd;
            r_q1_qq    <= pq3 * pq3;
            r_q1_a2    <= (pcd >>> 2) * c_p8;
            r_q1_q82   <= pq8 * pq8;
            r_q1_q8    <= pq8;
            r_q1_fault <= dv_side_out.fault;
        end
    end

    // post-divide stage 2
    logic signed [31:0] r_q2_v1m, r_q2_v2, r_q2_q83, r_q2_pc;
    logic               r_q2_fault;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q2_v1m   <= c_p9 * (r_q1_qq >>> 13);
            r_q2_v2    <= r_q1_a2 >>> 13;
            r_q2_q83   <= r_q1_q82 * r_q1_q8;
            r_q2_pc    <= r_q1_pc;
            r_q2_fault <= r_q1_fault;
        end
    end

    // post-divide stage 3
    logic signed [31:0] r_q3_v1, r_q3_v2, r_q3_v3m, r_q3_pc;
    logic               r_q3_fault;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q3_v1    <= r_q2_v1m >>> 12;
            r_q3_v2    <= r_q2_v2;
            r_q3_v3m   <= r_q2_q83 * c_p10;
            r_q3_pc    <= r_q2_pc;
            r_q3_fault <= r_q2_fault;
        end
    end

    // ---------------------------------------------------------------- humidity
    // stage 6: products with temperature
    logic signed [31:0] r_h1_m3, r_h1_m4, r_h1_m5, r_h1_m7, r_h1_ts;
    logic [15:0]        r_h1_rh;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h1_m3 <= r_ts * c_h3;
            r_h1_m4 <= r_ts * c_h4;
            r_h1_m5 <= r_ts * c_h5;
            r_h1_m7 <= r_ts * c_h7;
            r_h1_ts <= r_ts;
            r_h1_rh <= r_s5_rh;
        end
    end

    // stages 7 and 8: divide by 100
    logic signed [31:0] hd3, hd4, hd5, hd7;
    logic signed [31:0] r_h2_ts, r_h3_ts;
    logic [15:0]        r_h2_rh, r_h3_rh;

    esc_div100 u_d3 (.i_clk(i_clk), .i_en(adv), .i_x(r_h1_m3), .o_q(hd3));
    esc_div100 u_d4 (.i_clk(i_clk), .i_en(adv), .i_x(r_h1_m4), .o_q(hd4));
    esc_div100 u_d5 (.i_clk(i_clk), .i_en(adv), .i_x(r_h1_m5), .o_q(hd5));
    esc_div100 u_d7 (.i_clk(i_clk), .i_en(adv), .i_x(r_h1_m7), .o_q(hd7));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h2_ts <= r_h1_ts;
            r_h2_rh <= r_h1_rh;
            r_h3_ts <= r_h2_ts;
            r_h3_rh <= r_h2_rh;
        end
    end

    // stage 9: var1, var4 and the quadratic product
    logic signed [31:0] hv4a;
    logic signed [31:0] r_h4_m5b, r_h4_v1, r_h4_v4, r_h4_d4;

    assign hv4a = (c_h6 <<< 7) + hd7;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h4_m5b <= r_h3_ts * hd5;
            r_h4_v1  <= $signed({16'd0, r_h3_rh}) - (c_h1 <<< 4) - (hd3 >>> 1);
            r_h4_v4  <= hv4a >>> 4;
            r_h4_d4  <= hd4;
        end
    end

    // stages 10 and 11: quadratic term divide by 100
    logic signed [31:0] hm5s, he;
    logic signed [31:0] r_h5_v1, r_h5_v4, r_h5_d4, r_h6_v1, r_h6_v4, r_h6_d4;

    assign hm5s = r_h4_m5b >>> 6;

    esc_div100 u_d5b (.i_clk(i_clk), .i_en(adv), .i_x(hm5s), .o_q(he));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h5_v1 <= r_h4_v1;
            r_h5_v4 <= r_h4_v4;
            r_h5_d4 <= r_h4_d4;
            r_h6_v1 <= r_h5_v1;
            r_h6_v4 <= r_h5_v4;
            r_h6_d4 <= r_h5_d4;
        end
    end

    // stage 12: scale var2 by H2
    logic signed [31:0] r_h7_v2m, r_h7_v1, r_h7_v4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h7_v2m <= c_h2 * (r_h6_d4 + he + 32'sd16384);
            r_h7_v1  <= r_h6_v1;
            r_h7_v4  <= r_h6_v4;
        end
    end

    // stage 13: var3
    logic signed [31:0] r_h8_v3, r_h8_v4;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h8_v3 <= r_h7_v1 * (r_h7_v2m >>> 10);
            r_h8_v4 <= r_h7_v4;
        end
    end

    // stage 14: square of var3
    logic signed [31:0] hv3s;
    logic signed [31:0] r_h9_sq, r_h9_v3, r_h9_v4;

    assign hv3s = r_h8_v3 >>> 14;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h9_sq <= hv3s * hv3s;
            r_h9_v3 <= r_h8_v3;
            r_h9_v4 <= r_h8_v4;
        end
    end

    // stage 15: var6 product
    logic signed [31:0] r_h10_v6m, r_h10_v3;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h10_v6m <= r_h9_v4 * (r_h9_sq >>> 10);
            r_h10_v3  <= r_h9_v3;
        end
    end

    // stage 16: scale to milli-percent
    logic signed [31:0] hsum;
    logic signed [31:0] r_h11_chm;

    assign hsum = r_h10_v3 + (r_h10_v6m >>> 1);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_h11_chm <= (hsum >>> 10) * 32'sd1000;
        end
    end

    // temperature rides along the humidity stages
    logic signed [15:0] r_hts [HUM_END-6];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hts[0] <= r_ts[15:0];
            for (int k = 1; k < HUM_END - 6; k++) begin
                r_hts[k] <= r_hts[k-1];
            end
        end
    end

    // stage 17: clamp, then delay to meet the pressure result
    logic signed [31:0] hch;
    logic [16:0]        hclamp;
    logic [32:0]        r_dly [HUM_DLY];

    assign hch = r_h11_chm >>> 12;

    always_comb begin
        priority if (hch > $signed({15'd0, HUM_MAX})) begin
            hclamp = HUM_MAX;
        end else if (hch < 32'sd0) begin
            hclamp = '0;
        end else begin
            hclamp = hch[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dly[0] <= {r_hts[HUM_END-7], hclamp};
            for (int k = 1; k < HUM_DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // ---------------------------------------------------------------- output stage
    logic signed [31:0] psum;
    logic signed [15:0] r_o_t;
    logic [31:0]        r_o_p;
    logic [16:0]        r_o_h;
    logic               r_o_f;

    assign psum = r_q3_v1 + r_q3_v2 + (r_q3_v3m >>> 17) + (c_p7 <<< 7);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_t <= $signed(r_dly[HUM_DLY-1][32:17]);
            r_o_h <= r_dly[HUM_DLY-1][16:0];
            r_o_p <= r_q3_fault ? 32'd0 : 32'(r_q3_pc + (psum >>> 4));
            r_o_f <= r_q3_fault;
        end
    end

    assign o_temperature_centi = r_o_t;
    assign o_pressure_pa       = r_o_p;
    assign o_humidity_milli    = r_o_h;
    assign o_divide_fault      = r_o_f;

    // ---------------------------------------------------------------- checks
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_fault |-> o_pressure_pa == 32'd0)
        else $error("divide fault with nonzero pressure");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_humidity_milli <= HUM_MAX)
        else $error("humidity above clamp");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted transaction not in first stage");

endmodule

// File: bench/testbench.sv
// testbench for env_sensor_compensation_unit: drives sample transactions and
// checks each result against an integer compensation predictor; uses esc_pkg
`timescale 1ns / 1ps

module testbench;
    import esc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    logic [19:0] i_raw_temperature;
    logic [19:0] i_raw_pressure;
    logic [15:0] i_raw_humidity;
    logic        o_valid;
    logic        i_stall;
    logic signed [15:0] o_temperature_centi;
    logic [31:0] o_pressure_pa;
    logic [16:0] o_humidity_milli;
    logic        o_divide_fault;

    typedef struct packed {
        logic [19:0] t;
        logic [19:0] p;
        logic [15:0] h;
    } t_sample;

    typedef struct packed {
        logic [15:0] temp;
        logic [31:0] pres;
        logic [16:0] hum;
        logic        fault;
    } t_comp;

    t_sample     sample_q[$];
    t_comp       comp_q[$];
    logic [63:0] coef[6];
    int          err_cnt = 0;
    int          tx_gap;
    int          rx_gap;
    logic        feeding;

    env_sensor_compensation_unit u_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .i_valid, .o_stall, .i_raw_temperature, .i_raw_pressure,
        .i_raw_humidity, .o_valid, .i_stall, .o_temperature_centi,
        .o_pressure_pa, .o_humidity_milli, .o_divide_fault
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // signed field of a coefficient word
    function automatic int sf(input logic [63:0] v, input int lo, input int w);
        logic [63:0] f;
        f = (v >> lo) & ((64'd1 << w) - 1);
        if (f[w-1]) return int'($signed(f) - $signed(64'd1 << w));
        return int'(f);
    endfunction

    function automatic int uf(input logic [63:0] v, input int lo, input int w);
        return int'((v >> lo) & ((64'd1 << w) - 1));
    endfunction

    // truncating divide with the most negative by -1 wrap
    function automatic int tdiv(input int a, input int b);
        if (a == 32'sh80000000 && b == -1) return a;
        return a / b;
    endfunction

    // integer compensation of one sample
    function automatic t_comp compensate(input t_sample s);
        longint t1, t2, t3, a, b, c;
        int p1, p2, p3, p4, p5, p6, p7, p8, p9, p10;
        int h1, h2, h3, h4, h5, h6, h7;
        int tf, ts, v1, v2, v3, v4, v5, v6, q, pc, ch;
        t_comp r;
        t1 = uf(coef[REG_TEMP], 0, 16);
        t2 = sf(coef[REG_TEMP], 16, 16);
        t3 = sf(coef[REG_TEMP], 32, 8);
        p1 = uf(coef[REG_PRES_A], 0, 16);
        p2 = sf(coef[REG_PRES_A], 16, 16);
        p3 = sf(coef[REG_PRES_A], 32, 8);
        p4 = sf(coef[REG_PRES_A], 40, 16);
        p5 = sf(coef[REG_PRES_B], 0, 16);
        p6 = sf(coef[REG_PRES_B], 16, 8);
        p7 = sf(coef[REG_PRES_B], 24, 8);
        p8 = sf(coef[REG_PRES_B], 32, 16);
        p9 = sf(coef[REG_PRES_C], 0, 16);
        p10 = uf(coef[REG_PRES_C], 16, 8);
        h1 = uf(coef[REG_HUM_A], 0, 12);
        h2 = uf(coef[REG_HUM_A], 12, 12);
        h3 = sf(coef[REG_HUM_B], 0, 8);
        h4 = sf(coef[REG_HUM_B], 8, 8);
        h5 = sf(coef[REG_HUM_B], 16, 8);
        h6 = uf(coef[REG_HUM_B], 24, 8);
        h7 = sf(coef[REG_HUM_B], 32, 8);
        r.fault = 1'b0;

        // temperature in 64 bits
        a = longint'(s.t >> 3) - t1 * 2;
        b = (a * t2) >>> 11;
        c = a >>> 1;
        c = (c * c) >>> 12;
        c = (c * (t3 * 16)) >>> 14;
        tf = int'(b + c);
        ts = (tf * 5 + 128) >>> 8;

        // pressure, 32-bit wrap
        v1 = (tf >>> 1) - 64000;
        q = v1 >>> 2;
        v2 = (((q * q) >>> 11) * p6) >>> 2;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = (v2 >>> 2) + (p4 << 16);
        v1 = (((((q * q) >>> 13) * (p3 << 5)) >>> 3) + ((p2 * v1) >>> 1)) >>> 18;
        v1 = ((32768 + v1) * p1) >>> 15;
        pc = 1048576 - int'(s.p);
        pc = (pc - (v2 >>> 12)) * 3125;
        if (v1 == 0) begin
            r.fault = 1'b1;
            pc = 0;
        end else begin
            if (pc >= OVF_LIMIT) pc = tdiv(pc, v1) << 1;
            else pc = tdiv(pc << 1, v1);
            q = pc >>> 3;
            v1 = (p9 * ((q * q) >>> 13)) >>> 12;
            v2 = ((pc >>> 2) * p8) >>> 13;
            q = pc >>> 8;
            v3 = (q * q * q * p10) >>> 17;
            pc = pc + ((v1 + v2 + v3 + (p7 << 7)) >>> 4);
        end

        // humidity
        v1 = int'(s.h) - h1 * 16 - (((ts * h3) / 100) >>> 1);
        v2 = (ts * h4) / 100 + (((ts * ((ts * h5) / 100)) >>> 6) / 100);
        v2 = (h2 * (v2 + 16384)) >>> 10;
        v3 = v1 * v2;
        v4 = (h6 * 128 + (ts * h7) / 100) >>> 4;
        v5 = ((v3 >>> 14) * (v3 >>> 14)) >>> 10;
        v6 = (v4 * v5) >>> 1;
        ch = ((((v3 + v6) >>> 10) * 1000)) >>> 12;
        if (ch > 100000) ch = 100000;
        else if (ch < 0) ch = 0;

        r.temp = ts[15:0];
        r.pres = pc;
        r.hum = ch[16:0];
        return r;
    endfunction

    task automatic report(input string what);
        $display("mismatch: %s", what);
        err_cnt++;
    endtask

    // sample driver, a zero gap presents the next transaction right away
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_valid           <= 1'b0;
            i_raw_temperature <= '0;
            i_raw_pressure    <= '0;
            i_raw_humidity    <= '0;
            tx_gap            <= 0;
        end else if (i_valid && !o_stall) begin
            comp_q.push_back(compensate({i_raw_temperature, i_raw_pressure,
                                         i_raw_humidity}));
            void'(sample_q.pop_front());
            gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
            if (gap == 0 && feeding && sample_q.size() > 0) begin
                i_raw_temperature <= sample_q[0].t;
                i_raw_pressure    <= sample_q[0].p;
                i_raw_humidity    <= sample_q[0].h;
            end else begin
                i_valid <= 1'b0;
                tx_gap  <= gap;
            end
        end else if (!i_valid && tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
        end else if (!i_valid && feeding && sample_q.size() > 0) begin
            i_valid           <= 1'b1;
            i_raw_temperature <= sample_q[0].t;
            i_raw_pressure    <= sample_q[0].p;
            i_raw_humidity    <= sample_q[0].h;
        end
    end

    // result monitor and stall
    always @(posedge i_clk) begin
        t_comp exp_c;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_gap  <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (comp_q.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    exp_c = comp_q.pop_front();
                    if (o_temperature_centi !== exp_c.temp)
                        report($sformatf("temperature %0d exp %0d",
                            o_temperature_centi, $signed(exp_c.temp)));
                    if (o_pressure_pa !== exp_c.pres)
                        report($sformatf("pressure %0h exp %0h", o_pressure_pa,
                            exp_c.pres));
                    if (o_humidity_milli !== exp_c.hum)
                        report($sformatf("humidity %0d exp %0d", o_humidity_milli,
                            exp_c.hum));
                    if (o_divide_fault !== exp_c.fault)
                        report($sformatf("fault %0b exp %0b", o_divide_fault,
                            exp_c.fault));
                end
                rx_gap <= $urandom_range(3) == 0 ? 0 : $urandom_range(12);
            end
            if (rx_gap > 0) begin
                i_stall <= 1'b1;
                if (!(o_valid && !i_stall)) rx_gap <= rx_gap - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // register write, setup then access
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] v);
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= 6'(8 * int'(idx));
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP:   coef[idx] = v & 64'hFF_FFFF_FFFF;
            REG_PRES_A: coef[idx] = v & 64'hFF_FFFF_FFFF_FFFF;
            REG_PRES_B: coef[idx] = v & 64'hFFFF_FFFF_FFFF;
            REG_HUM_B:  coef[idx] = v & 64'hFF_FFFF_FFFF;
            default:    coef[idx] = v & 64'hFF_FFFF;
        endcase
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    // typical sensor calibration with random jitter
    task automatic load_typical();
        write_reg(REG_TEMP, {8'(3), 16'(26500 + $urandom_range(400)),
                             16'(26000 + $urandom_range(1000))});
        write_reg(REG_PRES_A, {16'(4000 + $urandom_range(2000)), 8'(88),
                               16'(16'hD5F3 + $urandom_range(200)),
                               16'(35000 + $urandom_range(3000))});
        write_reg(REG_PRES_B, {16'(16'hF3B0 + $urandom_range(300)), 8'(30), 8'(30),
                               16'(16'hFF00 + $urandom_range(200))});
        write_reg(REG_PRES_C, {8'(30), 16'(16'hFA00 + $urandom_range(300))});
        write_reg(REG_HUM_A, {12'(1000 + $urandom_range(100)),
                              12'(750 + $urandom_range(200))});
        write_reg(REG_HUM_B, {8'(8'hF8 + $urandom_range(4)), 8'(45), 8'(20),
                              8'(45), 8'(8'hFE)});
    endtask

    task automatic run_phase(input int n, input bit realistic);
        t_sample s;
        for (int k = 0; k < n; k++) begin
            s = 56'({$urandom(), $urandom()});
            if (realistic && $urandom_range(4) != 0) begin
                s.t = 20'(400000 + $urandom_range(200000));
                s.p = 20'(300000 + $urandom_range(300000));
                s.h = 16'(15000 + $urandom_range(30000));
            end
            sample_q.push_back(s);
        end
        feeding = 1'b1;
        wait (sample_q.size() == 0 && comp_q.size() == 0);
        feeding = 1'b0;
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    initial begin
        t_sample s;
        feeding = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        for (int k = 0; k < 6; k++) coef[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset coefficients: zero divisor, field extremes
        for (int k = 0; k < 4; k++) begin
            s.t = k[0] ? 20'hFFFFF : 20'h0;
            s.p = k[1] ? 20'hFFFFF : 20'h0;
            s.h = k[0] ? 16'h0 : 16'hFFFF;
            sample_q.push_back(s);
        end
        run_phase(0, 1'b0);

        // typical calibration, directed extremes and realistic samples
        load_typical();
        sample_q.push_back({20'h0, 20'h0, 16'h0});
        sample_q.push_back({20'hFFFFF, 20'hFFFFF, 16'hFFFF});
        sample_q.push_back({20'd500000, 20'd400000, 16'd0});
        sample_q.push_back({20'd500000, 20'd400000, 16'hFFFF});
        sample_q.push_back({20'd500000, 20'h0, 16'd30000});
        run_phase(200, 1'b1);

        // all ones: extreme coefficients
        for (int k = 0; k < 6; k++) write_reg(t_reg_idx'(k), '1);
        run_phase(60, 1'b0);

        // negative divisor with large dividend: p1 at max, p2 most negative, divisor product wraps
        write_reg(REG_TEMP, 64'h0);
        write_reg(REG_PRES_A, {16'h0, 8'h0, 16'h8000, 16'hFFFF});
        write_reg(REG_PRES_B, 64'h0);
        write_reg(REG_PRES_C, 64'h0);
        run_phase(40, 1'b0);

        // fully random coefficient sets
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 6; k++) write_reg(t_reg_idx'(k), rnd64());
            run_phase(50, 1'b0);
        end

        // back to typical with jitter
        for (int r = 0; r < 2; r++) begin
            load_typical();
            run_phase(120, 1'b1);
        end

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
